[sv/dual_pid_differential_drive_assert.svh]
// Assertion macros used by the top-level module to check its own logic.
`ifndef DUAL_PID_DIFFERENTIAL_DRIVE_ASSERT_SVH
`define DUAL_PID_DIFFERENTIAL_DRIVE_ASSERT_SVH

// A condition that must be followed by another in the next cycle.
`define DPD_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

// A condition that must hold whenever another one does.
`define DPD_ASSERT_NOW(label, clk, rst_n, cond, res, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (res)) \
        else $error(msg);

`endif

[sv/dpd_pkg.sv]
package dpd_pkg;

    localparam int SampleRateHz = 100;
    localparam int GainW = 24;
    localparam int LimW = 31;
    localparam int CfgW = 31;
    localparam int IdxW = 3;

    typedef enum logic [IdxW-1:0] {
        REG_KP_LIN = 3'd0,
        REG_KI_LIN = 3'd1,
        REG_KP_ANG = 3'd2,
        REG_KI_ANG = 3'd3,
        REG_KD     = 3'd4,
        REG_P_LIM  = 3'd5,
        REG_I_LIM  = 3'd6,
        REG_D_LIM  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] linear_setpoint;
        logic signed [31:0] linear_measured;
        logic signed [31:0] angular_setpoint;
        logic signed [31:0] angular_measured;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] left_command;
        logic signed [31:0] right_command;
        logic signed [31:0] linear_correction;
        logic signed [31:0] angular_correction;
    } out_beat_t;

    // Controller steps.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_BDIV,
        ST_P,
        ST_INT,
        ST_I,
        ST_D,
        ST_SUM,
        ST_MIX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;     // capture input beat
        logic axis;     // 0 linear, 1 angular
        logic err;      // form error and derivative difference
        logic bdiv_go;  // start bound division
        logic do_p;
        logic do_int;
        logic do_i;
        logic do_d;
        logic do_sum;
        logic do_mix;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } sts_t;

    function automatic logic signed [63:0] floor_q16(input logic signed [63:0] v);
        return v >>> 16;
    endfunction

    function automatic logic signed [63:0] clamp_sym(input logic signed [63:0] v,
                                                      input logic [63:0] lim);
        logic signed [63:0] l;
        l = $signed(lim);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

[sv/dual_pid_differential_drive.sv]
// Channel  Ports                     Payload
// input    s_valid/s_ready/s_data    setpoints and measurements, both axes
// result   m_valid/m_ready/m_data    motor commands and corrections
// config   cfg_we/cfg_idx/cfg_data   gain and limit registers
// Each axis runs one error step, the integral bound on the shared 48-step
// divider, and five arithmetic steps; after the angular axis the corrections
// are mixed and m_valid rises.
// Synchronous active-low reset clears state, integrals and previous errors.
// The result is held until taken; the next input beat waits for that.
module dual_pid_differential_drive
    import dpd_pkg::*;
#(
    parameter int SAMPLE_RATE_HZ = SampleRateHz
)(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  in_beat_t        s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output out_beat_t       m_data,
    input  logic            cfg_we,
    input  logic [IdxW-1:0] cfg_idx,
    input  logic [CfgW-1:0] cfg_data
);
    `include "dual_pid_differential_drive_assert.svh"

    logic [GainW-1:0] kp_lin_reg, ki_lin_reg, kp_ang_reg, ki_ang_reg, kd_reg;
    logic [LimW-1:0]  p_lim_reg, i_lim_reg, d_lim_reg;
    cmd_t cmd;
    sts_t sts;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_lin_reg <= 24'd52429;
            ki_lin_reg <= 24'd327680;
            kp_ang_reg <= 24'd52429;
            ki_ang_reg <= 24'd131072;
            kd_reg     <= 24'd0;
            p_lim_reg  <= 31'd6553600;
            i_lim_reg  <= 31'd3276800;
            d_lim_reg  <= 31'd0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_idx))
                REG_KP_LIN: kp_lin_reg <= cfg_data[GainW-1:0];
                REG_KI_LIN: ki_lin_reg <= cfg_data[GainW-1:0];
                REG_KP_ANG: kp_ang_reg <= cfg_data[GainW-1:0];
                REG_KI_ANG: ki_ang_reg <= cfg_data[GainW-1:0];
                REG_KD:     kd_reg     <= cfg_data[GainW-1:0];
                REG_P_LIM:  p_lim_reg  <= cfg_data;
                REG_I_LIM:  i_lim_reg  <= cfg_data;
                REG_D_LIM:  d_lim_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    dpd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    dpd_datapath #(.SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts), .s_beat(s_data),
        .kp_lin(kp_lin_reg), .ki_lin(ki_lin_reg), .kp_ang(kp_ang_reg),
        .ki_ang(ki_ang_reg), .kd(kd_reg), .p_lim(p_lim_reg), .i_lim(i_lim_reg),
        .d_lim(d_lim_reg), .m_beat(m_data)
    );

    // Input and result never handshake together.
    `DPD_ASSERT_NOW(a_excl, aclk, aresetn, s_ready, !m_valid, "ready while result pending")
    // A taken input beat starts work, so no ready next cycle.
    `DPD_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "ready after accept")
    // A delivered result reopens the input.
    `DPD_ASSERT_NEXT(a_done, aclk, aresetn, m_valid && m_ready, s_ready, "not idle after result")
endmodule

[sv/dpd_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned.
module dpd_div
    import dpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [47:0] divisor,
    output logic [47:0] quotient,
    output logic        done
);
    logic [47:0] q_reg;
    logic [48:0] r_reg;
    logic [47:0] d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [48:0] trial;

    assign trial = {r_reg[47:0], q_reg[47]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd48;
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
            end else if (busy_reg) begin
                if (trial >= {1'b0, d_reg}) begin
                    r_reg <= trial - {1'b0, d_reg};
                    q_reg <= {q_reg[46:0], 1'b1};
                end else begin
                    r_reg <= trial;
                    q_reg <= {q_reg[46:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = q_reg;
    assign done = done_reg;
endmodule

[sv/dpd_datapath.sv]
// Per-axis PID arithmetic, state, and output mixing.
module dpd_datapath
    import dpd_pkg::*;
#(
    parameter int SAMPLE_RATE_HZ = SampleRateHz
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  in_beat_t    s_beat,
    input  logic [GainW-1:0] kp_lin,
    input  logic [GainW-1:0] ki_lin,
    input  logic [GainW-1:0] kp_ang,
    input  logic [GainW-1:0] ki_ang,
    input  logic [GainW-1:0] kd,
    input  logic [LimW-1:0]  p_lim,
    input  logic [LimW-1:0]  i_lim,
    input  logic [LimW-1:0]  d_lim,
    output out_beat_t   m_beat
);
    localparam logic [63:0] Rate64 = 64'(SAMPLE_RATE_HZ);
    // Reciprocal of the sample rate, exact for any 32-bit error magnitude.
    localparam int RecipS = 32 + $clog2(SAMPLE_RATE_HZ);
    localparam logic [63:0] RecipFull = ((64'd1 << RecipS) + Rate64 - 64'd1) / Rate64;
    localparam logic [32:0] RecipM = 33'(RecipFull);

    in_beat_t in_reg;
    logic signed [47:0] integ_reg [2];
    logic signed [32:0] prev_reg  [2];
    logic signed [32:0] err_reg;
    logic signed [33:0] diff_reg;
    logic [47:0]        dmag_reg;
    logic               dneg_reg;
    logic signed [47:0] equot_reg;
    logic signed [63:0] p_reg, i_reg, d_reg;
    logic signed [31:0] corr_reg [2];
    logic [47:0]        bound_reg;
    out_beat_t          out_reg;

    logic [GainW-1:0]   kp_sel, ki_sel;
    logic               ax;
    logic               div_start;
    logic [47:0]        div_a, div_b, div_q;
    logic               div_done;
    logic [31:0]        emag;
    logic [64:0]        rprod;
    logic [64:0]        rquot;
    logic signed [32:0] e_new;
    logic signed [63:0] isum;
    logic [63:0]        dscale;
    logic [71:0]        dprod;
    logic signed [63:0] dpos;
    logic signed [63:0] ssum;

    assign ax     = cmd.axis;
    assign kp_sel = ax ? kp_ang : kp_lin;
    assign ki_sel = ax ? ki_ang : ki_lin;
    assign e_new  = ax ? (33'(in_reg.angular_setpoint) - 33'(in_reg.angular_measured))
                       : (33'(in_reg.linear_setpoint) - 33'(in_reg.linear_measured));
    assign emag   = err_reg[32] ? 32'(-err_reg) : 32'(err_reg);

    // The divider computes the integral bound; the rate divide uses the reciprocal.
    assign div_start = cmd.bdiv_go;
    assign div_a = {1'b0, i_lim, 16'd0};
    assign div_b = 48'(ki_sel);

    dpd_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_a), .divisor(div_b), .quotient(div_q), .done(div_done)
    );
    assign sts.div_done = div_done;

    assign rprod  = 65'(emag) * 65'(RecipM);
    assign rquot  = rprod >> RecipS;
    assign isum   = 64'(integ_reg[ax]) + 64'(equot_reg);
    assign dscale = {16'd0, dmag_reg} * Rate64;
    assign dprod  = 72'(dmag_reg) * 72'(kd);
    assign dpos   = $signed({16'd0, dprod[47:0]});
    assign ssum   = p_reg + i_reg + d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg[0] <= '0;
            integ_reg[1] <= '0;
            prev_reg[0]  <= '0;
            prev_reg[1]  <= '0;
        end else begin
            if (cmd.load) in_reg <= s_beat;
            if (div_done) bound_reg <= (ki_sel == '0) ? '0 : div_q;
            if (cmd.err) begin
                err_reg <= e_new;
                diff_reg <= (34'(e_new) - 34'(prev_reg[ax]));
                prev_reg[ax] <= e_new;
            end
            if (cmd.do_p) begin
                p_reg <= clamp_sym(floor_q16(64'(err_reg) * $signed({40'd0, kp_sel})),
                                   64'(p_lim));
                // Error over the sample rate, rounded toward zero.
                equot_reg <= err_reg[32] ? -$signed({16'd0, rquot[31:0]})
                                         : $signed({16'd0, rquot[31:0]});
                // Derivative magnitude, scaled by the rate on the next step.
                dneg_reg <= diff_reg[33];
                dmag_reg <= diff_reg[33] ? 48'(-diff_reg) : 48'(diff_reg);
            end
            if (cmd.do_int) begin
                integ_reg[ax] <= 48'(clamp_sym(isum, 64'(bound_reg)));
                // Magnitudes past 48 bits saturate D either way, so they are capped.
                dmag_reg <= (dscale[63:48] != '0) ? '1 : dscale[47:0];
            end
            if (cmd.do_i)
                i_reg <= floor_q16(64'(integ_reg[ax]) * $signed({40'd0, ki_sel}));
            if (cmd.do_d) begin
                if (kd == '0) begin
                    d_reg <= '0;
                end else if (dprod[71:48] != '0) begin
                    d_reg <= dneg_reg ? -64'(d_lim) : 64'(d_lim);
                end else begin
                    d_reg <= clamp_sym(floor_q16(dneg_reg ? -dpos : dpos), 64'(d_lim));
                end
            end
            if (cmd.do_sum) corr_reg[ax] <= sat32(ssum);
            if (cmd.do_mix) begin
                out_reg.left_command  <= sat32(64'(corr_reg[0]) - 64'(corr_reg[1]));
                out_reg.right_command <= sat32(-(64'(corr_reg[0]) + 64'(corr_reg[1])));
                out_reg.linear_correction  <= corr_reg[0];
                out_reg.angular_correction <= corr_reg[1];
            end
        end
    end

    assign m_beat = out_reg;
endmodule

[sv/dpd_ctrl.sv]
// Sequencer: walks both axes through the PID steps, then mixes.
module dpd_ctrl
    import dpd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;
    logic   axis_reg, axis_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd = '0;
        cmd.axis = axis_reg;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    axis_next = 1'b0;
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                cmd.err = 1'b1;
                cmd.bdiv_go = 1'b1;
                state_next = ST_BDIV;
            end
            ST_BDIV: if (sts.div_done) begin
                cmd.do_p = 1'b1;
                state_next = ST_P;
            end
            ST_P: begin
                cmd.do_int = 1'b1;
                state_next = ST_INT;
            end
            ST_INT: begin
                cmd.do_i = 1'b1;
                state_next = ST_I;
            end
            ST_I: begin
                cmd.do_d = 1'b1;
                state_next = ST_D;
            end
            ST_D: begin
                cmd.do_sum = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (axis_reg) begin
                    state_next = ST_MIX;
                end else begin
                    axis_next = 1'b1;
                    state_next = ST_ERR;
                end
            end
            ST_MIX: begin
                cmd.do_mix = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

[sim/dual_pid_differential_drive_tb.sv]
module dual_pid_differential_drive_tb;
    import dpd_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 200;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 210;

    typedef struct {
        logic [CfgW-1:0] kp_lin;
        logic [CfgW-1:0] ki_lin;
        logic [CfgW-1:0] kp_ang;
        logic [CfgW-1:0] ki_ang;
        logic [CfgW-1:0] kd;
        logic [CfgW-1:0] p_lim;
        logic [CfgW-1:0] i_lim;
        logic [CfgW-1:0] d_lim;
    } gain_set_t;

    // Holds the controller state and the commands still owed by the block.
    class drive_scoreboard;
        logic [GainW-1:0] kp [2];
        logic [GainW-1:0] ki [2];
        logic [GainW-1:0] kd;
        logic [LimW-1:0] p_lim;
        logic [LimW-1:0] i_lim;
        logic [LimW-1:0] d_lim;
        logic signed [63:0] integ [2];
        logic signed [63:0] prev_err [2];
        out_beat_t cmd_q[$];
        int mismatches;
        int failures;

        function void clear();
            kp[0] = 24'd52429;
            ki[0] = 24'd327680;
            kp[1] = 24'd52429;
            ki[1] = 24'd131072;
            kd = '0;
            p_lim = 31'd6553600;
            i_lim = 31'd3276800;
            d_lim = '0;
            integ[0] = '0;
            integ[1] = '0;
            prev_err[0] = '0;
            prev_err[1] = '0;
            mismatches = 0;
            failures = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [CfgW-1:0] val);
            case (idx)
                REG_KP_LIN: kp[0] = val[GainW-1:0];
                REG_KI_LIN: ki[0] = val[GainW-1:0];
                REG_KP_ANG: kp[1] = val[GainW-1:0];
                REG_KI_ANG: ki[1] = val[GainW-1:0];
                REG_KD:     kd = val[GainW-1:0];
                REG_P_LIM:  p_lim = val[LimW-1:0];
                REG_I_LIM:  i_lim = val[LimW-1:0];
                REG_D_LIM:  d_lim = val[LimW-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [63:0] clamp(logic signed [63:0] v, logic signed [63:0] lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function logic signed [63:0] sat(logic signed [63:0] v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // One PID correction for axis a; updates that axis's state.
        function logic signed [63:0] correction(int a, logic signed [63:0] e);
            logic signed [63:0] p, i, d, bound, slope, gkp, gki, gkd;
            logic [63:0] mag;
            gkp = {40'd0, kp[a]};
            gki = {40'd0, ki[a]};
            gkd = {40'd0, kd};
            p = clamp((gkp * e) >>> 16, {33'd0, p_lim});
            bound = (ki[a] == 0) ? 64'sd0 : $signed(({33'd0, i_lim} << 16) / {40'd0, ki[a]});
            integ[a] = clamp(integ[a] + e / SampleRateHz, bound);
            i = (gki * integ[a]) >>> 16;
            slope = (e - prev_err[a]) * SampleRateHz;
            if (kd == 0) begin
                d = '0;
            end else begin
                mag = (slope < 0) ? -slope : slope;
                // Derivative products past 48 bits go straight to the limit.
                if (mag > ((64'd1 << 48) - 1) / {40'd0, kd})
                    d = (slope < 0) ? -$signed({33'd0, d_lim}) : $signed({33'd0, d_lim});
                else
                    d = clamp((gkd * slope) >>> 16, {33'd0, d_lim});
            end
            prev_err[a] = e;
            return sat(p + i + d);
        endfunction

        function void note_input(in_beat_t b);
            logic signed [63:0] x, th;
            out_beat_t r;
            x = correction(0, 64'(b.linear_setpoint) - 64'(b.linear_measured));
            th = correction(1, 64'(b.angular_setpoint) - 64'(b.angular_measured));
            r.left_command = 32'(sat(x - th));
            r.right_command = 32'(sat(-(x + th)));
            r.linear_correction = 32'(x);
            r.angular_correction = 32'(th);
            cmd_q.push_back(r);
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            if (cmd_q.size() == 0) begin
                failures++;
                if (mismatches < 10)
                    $display("unexpected result beat %h", got);
                mismatches++;
                return;
            end
            want = cmd_q.pop_front();
            if (got.left_command !== want.left_command ||
                got.right_command !== want.right_command ||
                got.linear_correction !== want.linear_correction ||
                got.angular_correction !== want.angular_correction) begin
                failures++;
                if (mismatches < 10)
                    $display("mismatch: left %0d/%0d right %0d/%0d lin %0d/%0d ang %0d/%0d",
                             want.left_command, got.left_command,
                             want.right_command, got.right_command,
                             want.linear_correction, got.linear_correction,
                             want.angular_correction, got.angular_correction);
                mismatches++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_beat_t s_data;
    logic m_valid;
    logic m_ready;
    out_beat_t m_data;
    logic cfg_we;
    logic [IdxW-1:0] cfg_idx;
    logic [CfgW-1:0] cfg_data;

    drive_scoreboard sb;
    int hold_req;
    bit rx_bursty;
    bit tx_bursty;
    int cycles = 0;
    logic signed [31:0] bias_lin;
    logic signed [31:0] bias_ang;

    dual_pid_differential_drive u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Beat monitor on both channels.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // Run watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result receiver: random ready gaps, plus a long hold-off on request.
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req > 0) begin
                gap = hold_req;
                hold_req = 0;
            end else begin
                gap = rx_bursty ? 0 : $urandom_range(0, 19);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    task automatic send_beat(in_beat_t b);
        int gap;
        gap = tx_bursty ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CfgW-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge aclk);
    endtask

    // Stop offering beats and wait until the block has drained.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.cmd_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic load_gains(gain_set_t g);
        write_reg(REG_KP_LIN, g.kp_lin);
        write_reg(REG_KI_LIN, g.ki_lin);
        write_reg(REG_KP_ANG, g.kp_ang);
        write_reg(REG_KI_ANG, g.ki_ang);
        write_reg(REG_KD, g.kd);
        write_reg(REG_P_LIM, g.p_lim);
        write_reg(REG_I_LIM, g.i_lim);
        write_reg(REG_D_LIM, g.d_lim);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] small_speed();
        return $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
    endfunction

    function automatic logic signed [31:0] edge_speed();
        case ($urandom_range(0, 3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh0;
            default: return -32'sd1;
        endcase
    endfunction

    // Mostly steady tracking with a per-phase offset; some wild values mixed in.
    function automatic in_beat_t random_beat();
        in_beat_t b;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
            b.linear_setpoint = small_speed();
            b.linear_measured = b.linear_setpoint - bias_lin + (small_speed() >>> 4);
            b.angular_setpoint = small_speed();
            b.angular_measured = b.angular_setpoint - bias_ang + (small_speed() >>> 4);
        end else if (mode < 9) begin
            b.linear_setpoint = $urandom;
            b.linear_measured = $urandom;
            b.angular_setpoint = $urandom;
            b.angular_measured = $urandom;
        end else begin
            b.linear_setpoint = edge_speed();
            b.linear_measured = edge_speed();
            b.angular_setpoint = edge_speed();
            b.angular_measured = edge_speed();
        end
        return b;
    endfunction

    function automatic gain_set_t pick_gains(int phase);
        gain_set_t g;
        case (phase)
            0: begin
                // Everything at its top value; the gain writes also check masking.
                g = '{31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                      31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff};
            end
            1: g = '{31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0};
            2: begin
                // Zero integral gain on the angular axis, modest derivative.
                g = '{31'd65536, 31'd131072, 31'd32768, 31'd0,
                      31'd655, 31'd6553600, 31'd3276800, 31'd1638400};
            end
            3: begin
                // Shrinks the integral bound after the previous phase.
                g = '{31'd52429, 31'd16777215, 31'd52429, 31'd16777215,
                      31'd16777215, 31'h7fffffff, 31'd65536, 31'h7fffffff};
            end
            default: begin
                g.kp_lin = 31'($urandom_range(0, 32'h3ffff));
                g.ki_lin = 31'($urandom_range(0, 32'h7ffff));
                g.kp_ang = 31'($urandom_range(0, 32'h3ffff));
                g.ki_ang = 31'($urandom_range(0, 32'h7ffff));
                g.kd = 31'($urandom_range(0, 32'hfff));
                g.p_lim = 31'($urandom & 32'h7fffffff);
                g.i_lim = 31'($urandom_range(0, 32'h00ffffff));
                g.d_lim = 31'($urandom & 32'h7fffffff);
            end
        endcase
        return g;
    endfunction

    initial begin
        in_beat_t b;
        gain_set_t g;
        sb = new();
        sb.clear();
        hold_req = 0;
        rx_bursty = 1'b0;
        tx_bursty = 1'b0;
        bias_lin = 0;
        bias_ang = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed beats at reset gains: zero, extremes and rounding signs.
        send_beat('{32'sd0, 32'sd0, 32'sd0, 32'sd0});
        send_beat('{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff});
        send_beat('{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000});
        send_beat('{32'sd0, 32'sd1, 32'sd1, 32'sd0});
        send_beat('{-32'sd99, 32'sd0, 32'sd99, 32'sd0});
        send_beat('{-32'sd100, 32'sd0, 32'sd101, 32'sd0});
        send_beat('{32'sd65536, 32'sd0, -32'sd65536, 32'sd0});
        send_beat('{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000});
        drain();

        // Directed beats with a strong derivative and wide limits: huge slopes and mix overflow.
        load_gains('{31'd16777215, 31'd0, 31'd16777215, 31'd65536,
                     31'd16777215, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff});
        send_beat('{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff});
        send_beat('{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000});
        send_beat('{32'sd1, 32'sd0, -32'sd1, 32'sd0});
        send_beat('{32'sd100, 32'sd0, 32'sd100, 32'sd0});
        send_beat('{32'sh7fffffff, 32'sd0, 32'sh7fffffff, 32'sd0});
        send_beat('{32'sh80000000, 32'sd0, 32'sd0, 32'sh7fffffff});
        send_beat('{32'sd0, 32'sd0, 32'sd0, 32'sd0});
        send_beat('{32'sd5, 32'sd3, -32'sd5, 32'sd3});
        drain();

        // Random phases, each with its own gains, offsets and idling pattern.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            g = pick_gains(ph);
            load_gains(g);
            bias_lin = small_speed() >>> ($urandom_range(0, 8));
            bias_ang = small_speed() >>> ($urandom_range(0, 8));
            tx_bursty = (ph == 2);
            rx_bursty = (ph == 4);
            if (ph == 5) hold_req = 3000;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                b = random_beat();
                send_beat(b);
                // Let the result channel empty out once, midway through phase 6.
                if (ph == 6 && n == ITEMS_PER_PHASE / 2) begin
                    s_valid <= 1'b0;
                    while (sb.cmd_q.size() != 0) @(negedge aclk);
                end
            end
            drain();
        end

        if (sb.failures == 0 && sb.cmd_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[dual_pid_differential_drive.f]
+incdir+sv
sv/dpd_pkg.sv
sv/dpd_div.sv
sv/dpd_datapath.sv
sv/dpd_ctrl.sv
sv/dual_pid_differential_drive.sv
sim/dual_pid_differential_drive_tb.sv
